FILE: sv/assert_macros.svh
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: sv/nnis_pkg.sv
// Shared types and constants for the nearest-neighbor scaler.
`default_nettype none

package nnis_pkg;

    localparam int COORD_W  = 12;
    localparam int STEP_W   = 24;
    localparam int PROD_W   = COORD_W + STEP_W;
    localparam int FRAC_W   = 16;
    localparam int IDX_W    = PROD_W - FRAC_W + 1;

    localparam logic [FRAC_W-1:0] HALF_Q16    = 16'h8000;
    localparam logic [7:0]        GREY_CHROMA = 8'd128;

    // input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // command kinds carried from front to back
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] CMD_FETCH = 2'd1;
    localparam logic [KIND_W-1:0] CMD_ERR   = 2'd2;
    localparam logic [KIND_W-1:0] CMD_DROP  = 2'd3;

    // register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_X     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP_Y     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE = 3'd6;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  cr;
        logic [7:0]  cb;
        logic [15:0] value;
    } pix_t;

    typedef struct packed {
        logic [9:0]        src_width;
        logic [9:0]        src_height;
        logic [12:0]       out_width;
        logic [12:0]       out_height;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
        logic              color_mode;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/nnis_front.sv
// Front end: accepts beats, maps fetch coordinates, builds store commands.
`default_nettype none

module nnis_front #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_SIZE   = 4096,
    parameter int AW             = 18
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  nnis_pkg::cfg_t              cfg,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire                         op,
    input  wire [nnis_pkg::COORD_W-1:0] coord_x,
    input  wire [nnis_pkg::COORD_W-1:0] coord_y,
    input  wire [15:0]                  pixel_value,
    input  wire [7:0]                   chroma_b,
    input  wire [7:0]                   chroma_r,
    output logic                        push_valid,
    input  wire                         push_ready,
    output logic [nnis_pkg::KIND_W-1:0] push_kind,
    output logic [AW-1:0]               push_addr,
    output nnis_pkg::pix_t              push_pix
);
    import nnis_pkg::*;

    localparam int XW  = $clog2(MAX_SRC_WIDTH);
    localparam int YW  = $clog2(MAX_SRC_HEIGHT);
    localparam int SWW = ($clog2(MAX_SRC_WIDTH + 1) > 10) ? $clog2(MAX_SRC_WIDTH + 1) : 10;
    localparam int SHW = ($clog2(MAX_SRC_HEIGHT + 1) > 10) ? $clog2(MAX_SRC_HEIGHT + 1) : 10;
    localparam int OCW = ($clog2(MAX_OUT_SIZE + 1) > 13) ? $clog2(MAX_OUT_SIZE + 1) : 13;
    localparam int LCW = COORD_W + 1;

    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [PROD_W-1:0] s1_prod_x_reg;
    logic [PROD_W-1:0] s1_prod_y_reg;
    logic [XW-1:0]     s1_lx_reg;
    logic [YW-1:0]     s1_ly_reg;
    pix_t              s1_pix_reg;

    logic [KIND_W-1:0] kind_next;
    logic [OCW-1:0]    ow_eff;
    logic [OCW-1:0]    oh_eff;
    logic              fetch_oob;
    logic              load_in;
    logic              advance;

    logic [SWW-1:0]    sw_eff;
    logic [SHW-1:0]    sh_eff;
    logic [IDX_W-1:0]  last_x;
    logic [IDX_W-1:0]  last_y;
    logic [IDX_W-1:0]  idx_x;
    logic [IDX_W-1:0]  idx_y;
    logic [XW-1:0]     sx;
    logic [YW-1:0]     sy;

    // classification at the input
    always_comb
    begin
        ow_eff = (OCW'(cfg.out_width) > OCW'(MAX_OUT_SIZE)) ? OCW'(MAX_OUT_SIZE)
                                                            : OCW'(cfg.out_width);
        oh_eff = (OCW'(cfg.out_height) > OCW'(MAX_OUT_SIZE)) ? OCW'(MAX_OUT_SIZE)
                                                             : OCW'(cfg.out_height);
        fetch_oob = (OCW'(coord_x) >= ow_eff) || (OCW'(coord_y) >= oh_eff);
        load_in   = (LCW'(coord_x) < LCW'(MAX_SRC_WIDTH))
                 && (LCW'(coord_y) < LCW'(MAX_SRC_HEIGHT));
        if (op == OP_LOAD)
        begin
            kind_next = load_in ? CMD_LOAD : CMD_DROP;
        end
        else
        begin
            kind_next = fetch_oob ? CMD_ERR : CMD_FETCH;
        end
    end

    assign push_valid = s1_valid_reg && (s1_kind_reg != CMD_DROP);
    assign advance    = !s1_valid_reg || (s1_kind_reg == CMD_DROP) || push_ready;
    assign in_ready   = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= CMD_DROP;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s1_kind_reg  <= kind_next;
        end
    end

    // one 12x24 product per axis, registered
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s1_prod_x_reg    <= PROD_W'(coord_x) * PROD_W'(cfg.step_x);
            s1_prod_y_reg    <= PROD_W'(coord_y) * PROD_W'(cfg.step_y);
            s1_lx_reg        <= coord_x[XW-1:0];
            s1_ly_reg        <= coord_y[YW-1:0];
            s1_pix_reg.value <= pixel_value;
            s1_pix_reg.cb    <= chroma_b;
            s1_pix_reg.cr    <= chroma_r;
        end
    end

    // round ties down (bump only above one half), clamp to last column/row
    always_comb
    begin
        if (cfg.src_width == '0)
            sw_eff = SWW'(1);
        else if (SWW'(cfg.src_width) > SWW'(MAX_SRC_WIDTH))
            sw_eff = SWW'(MAX_SRC_WIDTH);
        else
            sw_eff = SWW'(cfg.src_width);

        if (cfg.src_height == '0)
            sh_eff = SHW'(1);
        else if (SHW'(cfg.src_height) > SHW'(MAX_SRC_HEIGHT))
            sh_eff = SHW'(MAX_SRC_HEIGHT);
        else
            sh_eff = SHW'(cfg.src_height);

        last_x = IDX_W'(sw_eff) - IDX_W'(1);
        last_y = IDX_W'(sh_eff) - IDX_W'(1);

        idx_x = IDX_W'(s1_prod_x_reg[PROD_W-1:FRAC_W])
              + IDX_W'(s1_prod_x_reg[FRAC_W-1:0] > HALF_Q16);
        idx_y = IDX_W'(s1_prod_y_reg[PROD_W-1:FRAC_W])
              + IDX_W'(s1_prod_y_reg[FRAC_W-1:0] > HALF_Q16);

        sx = (idx_x > last_x) ? last_x[XW-1:0] : idx_x[XW-1:0];
        sy = (idx_y > last_y) ? last_y[YW-1:0] : idx_y[YW-1:0];
    end

    always_comb
    begin
        push_kind = s1_kind_reg;
        push_pix  = s1_pix_reg;
        if (s1_kind_reg == CMD_LOAD)
            push_addr = AW'(s1_ly_reg) * AW'(MAX_SRC_WIDTH) + AW'(s1_lx_reg);
        else
            push_addr = AW'(sy) * AW'(MAX_SRC_WIDTH) + AW'(sx);
    end

endmodule

`default_nettype wire

FILE: sv/nnis_fifo.sv
// Command queue between the front end and the frame store.
`default_nettype none
`include "assert_macros.svh"

module nnis_fifo #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_CLK(a_no_overflow, clk, rst_n, !(push && full && !pop))
    `ASSERT_CLK(a_no_underflow, clk, rst_n, !(pop && !head_valid))
    `ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CW'(DEPTH))

endmodule

`default_nettype wire

FILE: sv/nnis_back.sv
// Back end: frame store, registered read and output register.
`default_nettype none
`include "assert_macros.svh"

module nnis_back #(
    parameter int STORE_DEPTH = 262144,
    parameter int AW          = 18
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         color_mode,
    input  wire                         head_valid,
    input  wire [nnis_pkg::KIND_W-1:0]  head_kind,
    input  wire [AW-1:0]                head_addr,
    input  nnis_pkg::pix_t              head_pix,
    output logic                        pop,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [15:0]                 out_value,
    output logic [7:0]                  out_chroma_b,
    output logic [7:0]                  out_chroma_r,
    output logic                        status
);
    import nnis_pkg::*;

    pix_t  store_mem [STORE_DEPTH];
    pix_t  rdata_reg;
    logic  rd_valid_reg;
    logic  rd_err_reg;
    logic  out_valid_reg;
    logic  rd_move;
    logic  rd_free;
    logic  head_is_load;
    logic  issue_read;

    assign head_is_load = (head_kind == CMD_LOAD);
    assign rd_move      = rd_valid_reg && (!out_valid_reg || out_ready);
    assign rd_free      = !rd_valid_reg || rd_move;
    assign pop          = head_valid && (head_is_load || rd_free);
    assign issue_read   = pop && !head_is_load;
    assign out_valid    = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop && head_is_load)
            store_mem[head_addr] <= head_pix;
        if (issue_read && (head_kind == CMD_FETCH))
            rdata_reg <= store_mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            rd_err_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue_read)
            begin
                rd_valid_reg <= 1'b1;
                rd_err_reg   <= (head_kind == CMD_ERR);
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            if (rd_err_reg)
            begin
                out_value    <= '0;
                out_chroma_b <= '0;
                out_chroma_r <= '0;
                status       <= 1'b1;
            end
            else
            begin
                out_value    <= rdata_reg.value;
                out_chroma_b <= color_mode ? rdata_reg.cb : GREY_CHROMA;
                out_chroma_r <= color_mode ? rdata_reg.cr : GREY_CHROMA;
                status       <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_read_lands, clk, rst_n, issue_read |=> rd_valid_reg)
    `ASSERT_CLK(a_no_read_clobber, clk, rst_n,
        !(issue_read && rd_valid_reg && !rd_move))

endmodule

`default_nettype wire

FILE: sv/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler: registers and block wiring.
`default_nettype none

// Nearest-neighbor image scaler with an on-chip frame store of
// MAX_SRC_WIDTH x MAX_SRC_HEIGHT 32-bit words (16-bit value, 8-bit Cb, 8-bit Cr).
// A load beat (op = 0) writes one source pixel; loads outside the store are
// dropped and give no result. A fetch beat (op = 1) gives exactly one result:
// each axis is mapped as coord * step (unsigned Q8.16), floored, bumped by one
// when the fraction is strictly above one half, and clamped to the last
// source column/row. Fetches at or beyond out_width/out_height return
// status = 1 with zero data. In grey mode (color_mode = 0) both chroma
// outputs read 128. Fetching a pixel that was never loaded returns
// undefined data; the store has no reset and needs no clearing pass.
// Throughput: one beat per clock while out_ready stays high. The front end
// registers one multiply per axis, then rounds/clamps and pushes into a
// four-entry command queue; the back end retires one command per cycle
// against the single-port store unless out_ready stalls. A fetch goes from
// input accept to out_valid via the product register, queue write, store
// read and output register, held while out_ready stalls. Loads issued
// before a fetch are always seen by it, since commands retire in order.
// Registers sit at paddr = 4*index: src_width, src_height, out_width,
// out_height, step_x, step_y, color_mode. Write them only while idle.

module nearest_neighbor_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_SIZE   = 4096
) (
    input  wire         clk,
    input  wire         rst_n,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         op,
    input  wire [11:0]  coord_x,
    input  wire [11:0]  coord_y,
    input  wire [15:0]  pixel_value,
    input  wire [7:0]   chroma_b,
    input  wire [7:0]   chroma_r,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] out_value,
    output logic [7:0]  out_chroma_b,
    output logic [7:0]  out_chroma_r,
    output logic        status
);
    import nnis_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = KIND_W + AW + $bits(pix_t);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    logic                 push_valid;
    logic [KIND_W-1:0]    push_kind;
    logic [AW-1:0]        push_addr;
    pix_t                 push_pix;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_head_valid;
    logic [ENTRY_W-1:0]   q_head;
    logic [KIND_W-1:0]    head_kind;
    logic [AW-1:0]        head_addr;
    pix_t                 head_pix;

    // ---------------------------------------------------------------
    // Config registers: write lands on the access phase
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= 10'd512;
            cfg_reg.src_height <= 10'd512;
            cfg_reg.out_width  <= 13'd512;
            cfg_reg.out_height <= 13'd512;
            cfg_reg.step_x     <= 24'h010000;
            cfg_reg.step_y     <= 24'h010000;
            cfg_reg.color_mode <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[9:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[9:0];
                REG_OUT_WIDTH:  cfg_reg.out_width  <= pwdata[12:0];
                REG_OUT_HEIGHT: cfg_reg.out_height <= pwdata[12:0];
                REG_STEP_X:     cfg_reg.step_x     <= pwdata[STEP_W-1:0];
                REG_STEP_Y:     cfg_reg.step_y     <= pwdata[STEP_W-1:0];
                REG_COLOR_MODE: cfg_reg.color_mode <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SRC_WIDTH:  prdata = 32'(cfg_reg.src_width);
            REG_SRC_HEIGHT: prdata = 32'(cfg_reg.src_height);
            REG_OUT_WIDTH:  prdata = 32'(cfg_reg.out_width);
            REG_OUT_HEIGHT: prdata = 32'(cfg_reg.out_height);
            REG_STEP_X:     prdata = 32'(cfg_reg.step_x);
            REG_STEP_Y:     prdata = 32'(cfg_reg.step_y);
            REG_COLOR_MODE: prdata = 32'(cfg_reg.color_mode);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front end: classify, map, build command
    // ---------------------------------------------------------------
    nnis_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_OUT_SIZE   (MAX_OUT_SIZE),
        .AW             (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .pixel_value (pixel_value),
        .chroma_b    (chroma_b),
        .chroma_r    (chroma_r),
        .push_valid  (push_valid),
        .push_ready  (!q_full),
        .push_kind   (push_kind),
        .push_addr   (push_addr),
        .push_pix    (push_pix)
    );

    // ---------------------------------------------------------------
    // Command queue decouples mapping from store access
    // ---------------------------------------------------------------
    nnis_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid && !q_full),
        .push_data  ({push_kind, push_addr, push_pix}),
        .full       (q_full),
        .pop        (q_pop),
        .head_data  (q_head),
        .head_valid (q_head_valid)
    );

    assign head_kind = q_head[ENTRY_W-1 -: KIND_W];
    assign head_addr = q_head[$bits(pix_t) +: AW];
    assign head_pix  = pix_t'(q_head[$bits(pix_t)-1:0]);

    // ---------------------------------------------------------------
    // Back end: frame store and result register
    // ---------------------------------------------------------------
    nnis_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .color_mode   (cfg_reg.color_mode),
        .head_valid   (q_head_valid),
        .head_kind    (head_kind),
        .head_addr    (head_addr),
        .head_pix     (head_pix),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .out_chroma_b (out_chroma_b),
        .out_chroma_r (out_chroma_r),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: bench/nearest_neighbor_image_scaler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_image_scaler: directed table, then random phases.

module nearest_neighbor_image_scaler_tb;

    import nnis_pkg::*;

    // Sizes the block is built with (its default parameters)
    localparam int MAX_SRC_W = 512;
    localparam int MAX_SRC_H = 512;
    localparam int MAX_OUT   = 4096;

    // Result status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_DIRECTED    = 21;
    localparam int HOLD_CYCLES     = 300;  // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES    = 8;    // margin for a trailing load to reach the store
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 6_000_000;

    // One returned pixel, as seen on the result channel
    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic        status;
    } out_pix_t;

    localparam out_pix_t RANGE_ERR = '{16'h0000, 8'h00, 8'h00, ST_RANGE};
    localparam out_pix_t NO_CHECK  = '0;

    // Directed stimulus row; chk marks a fetch whose result is typed in
    typedef struct packed {
        logic        chk;
        logic        op_code;
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] v;
        logic [7:0]  b;
        logic [7:0]  r;
        out_pix_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [15:0] pixel_value;
    logic [7:0]  chroma_b;
    logic [7:0]  chroma_r;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_value;
    logic [7:0]  out_chroma_b;
    logic [7:0]  out_chroma_r;
    logic        status;

    // Bench copy of the block's registers and frame store.
    // The store only holds entries that were actually loaded.
    cfg_t     scaler_cfg;
    pix_t     frame_pixels [int];
    out_pix_t pending_pixels [$];   // expected fetch results, oldest first
    dir_row_t directed_rows [NUM_DIRECTED];

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_req;

    int beat_count;
    int load_count;
    int dropped_count;
    int fetch_count;
    int range_count;
    int result_count;
    int fault_count;

    nearest_neighbor_image_scaler #(
        .MAX_SRC_WIDTH  (MAX_SRC_W),
        .MAX_SRC_HEIGHT (MAX_SRC_H),
        .MAX_OUT_SIZE   (MAX_OUT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .pixel_value  (pixel_value),
        .chroma_b     (chroma_b),
        .chroma_r     (chroma_r),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .out_chroma_b (out_chroma_b),
        .out_chroma_r (out_chroma_r),
        .status       (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Source size register as the block uses it: 0 acts as 1, caps at the store size
    function automatic int eff_size(logic [9:0] v, int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic int out_limit(logic [12:0] v);
        return (v > MAX_OUT) ? MAX_OUT : int'(v);
    endfunction

    // coord * step in Q8.16, floor, round up only when the fraction is above
    // one half, then saturate at the last source column/row
    function automatic int map_to_source(logic [11:0] coord, logic [23:0] step, int size);
        logic [35:0] pos;
        int          idx;
        pos = coord * step;
        idx = int'(pos[35:16]);
        if (pos[15:0] > HALF_Q16)
            idx++;
        if (idx > size - 1)
            idx = size - 1;
        return idx;
    endfunction

    function automatic bit fetch_in_range(logic [11:0] x, logic [11:0] y);
        return (x < out_limit(scaler_cfg.out_width)) && (y < out_limit(scaler_cfg.out_height));
    endfunction

    // Store address of the source pixel that an output coordinate lands on
    function automatic int source_addr(logic [11:0] x, logic [11:0] y);
        int sx;
        int sy;
        sx = map_to_source(x, scaler_cfg.step_x, eff_size(scaler_cfg.src_width, MAX_SRC_W));
        sy = map_to_source(y, scaler_cfg.step_y, eff_size(scaler_cfg.src_height, MAX_SRC_H));
        return sy * MAX_SRC_W + sx;
    endfunction

    function automatic out_pix_t scaled_pixel(logic [11:0] x, logic [11:0] y);
        out_pix_t res;
        pix_t     word;
        int       a;
        if (!fetch_in_range(x, y))
            return RANGE_ERR;
        a = source_addr(x, y);
        word = frame_pixels.exists(a) ? frame_pixels[a] : '0;
        res.value  = word.value;
        // grey mode hides the stored chroma but does not erase it
        res.cb     = scaler_cfg.color_mode ? word.cb : GREY_CHROMA;
        res.cr     = scaler_cfg.color_mode ? word.cr : GREY_CHROMA;
        res.status = ST_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Setup then access phase; psel stays up so writes can go back to back
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_config(cfg_t c);
        reg_write(REG_SRC_WIDTH,  32'(c.src_width));
        reg_write(REG_SRC_HEIGHT, 32'(c.src_height));
        reg_write(REG_OUT_WIDTH,  32'(c.out_width));
        reg_write(REG_OUT_HEIGHT, 32'(c.out_height));
        reg_write(REG_STEP_X,     32'(c.step_x));
        reg_write(REG_STEP_Y,     32'(c.step_y));
        reg_write(REG_COLOR_MODE, 32'(c.color_mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scaler_cfg = c;
    endtask

    // Register setting for each random phase. A few fixed corners, the rest random.
    function automatic cfg_t pick_setting(int ph);
        cfg_t c;
        c.src_width  = 10'($urandom_range(1, MAX_SRC_W));
        c.src_height = 10'($urandom_range(1, MAX_SRC_H));
        c.out_width  = 13'($urandom_range(1, MAX_OUT));
        c.out_height = 13'($urandom_range(1, MAX_OUT));
        // half the time a step that matches the size ratio, else anything
        c.step_x = $urandom_range(0, 1) ? 24'((int'(c.src_width) << 16) / int'(c.out_width))
                                        : 24'($urandom_range(1, 24'hFFFFFF));
        c.step_y = $urandom_range(0, 1) ? 24'((int'(c.src_height) << 16) / int'(c.out_height))
                                        : 24'($urandom_range(1, 24'hFFFFFF));
        c.color_mode = 1'($urandom);
        case (ph)
            0: // 8x upscale to the largest output, top rows/columns saturate
                c = '{src_width: 10'd512, src_height: 10'd512,
                      out_width: 13'd4096, out_height: 13'd4096,
                      step_x: 24'h002000, step_y: 24'h002000, color_mode: 1'b1};
            2: // smallest images, largest step, grey
                c = '{src_width: 10'd1, src_height: 10'd1,
                      out_width: 13'd1, out_height: 13'd1,
                      step_x: 24'hFFFFFF, step_y: 24'hFFFFFF, color_mode: 1'b0};
            3: // zero step: everything maps to column 0 / row 0
            begin
                c.step_x     = '0;
                c.step_y     = '0;
                c.out_width  = 13'(MAX_OUT);
                c.out_height = 13'(MAX_OUT);
                c.color_mode = 1'b1;
            end
            5: // from x = 2 on, x lands past the source edge; y never leaves row 0
                c = '{src_width: 10'd512, src_height: 10'd512,
                      out_width: 13'd4096, out_height: 13'd4096,
                      step_x: 24'hFFFFFF, step_y: 24'h000001, color_mode: 1'b1};
            7: // 1.5 and 0.5 steps land exactly on the half, which must not round up
                c = '{src_width: 10'd512, src_height: 10'd512,
                      out_width: 13'd341, out_height: 13'd1024,
                      step_x: 24'h018000, step_y: 24'h008000, color_mode: 1'b1};
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Offers one beat after a random number of idle cycles and waits for it to
    // be taken. The expectation is worked out in issue order, which is also
    // accept order, and queued once the beat is accepted.
    task automatic send_beat(logic o, logic [11:0] x, logic [11:0] y, logic [15:0] v,
                             logic [7:0] b, logic [7:0] r, bit typed, out_pix_t typed_want);
        out_pix_t want;
        bit       stored;
        stored = 1'b0;
        want   = typed_want;
        if (o == OP_FETCH)
        begin
            if (!typed)
                want = scaled_pixel(x, y);
        end
        else if (x < MAX_SRC_W && y < MAX_SRC_H)
        begin
            frame_pixels[int'(y) * MAX_SRC_W + int'(x)] = '{cr: r, cb: b, value: v};
            stored = 1'b1;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        coord_x     <= x;
        coord_y     <= y;
        pixel_value <= v;
        chroma_b    <= b;
        chroma_r    <= r;
        do @(posedge clk); while (!in_ready);
        beat_count++;
        if (o == OP_FETCH)
        begin
            pending_pixels.push_back(want);
            fetch_count++;
            if (want.status == ST_RANGE)
                range_count++;
        end
        else if (stored)
        begin
            load_count++;
        end
        else
        begin
            dropped_count++;
        end
    endtask

    // A fetch that would read a never-loaded pixel is preceded by a load of
    // that pixel; some fetches reload their pixel right before reading it.
    task automatic issue_fetch(logic [11:0] x, logic [11:0] y);
        int a;
        if (fetch_in_range(x, y))
        begin
            a = source_addr(x, y);
            if (!frame_pixels.exists(a) || $urandom_range(0, 99) < 25)
                send_beat(OP_LOAD, 12'(a % MAX_SRC_W), 12'(a / MAX_SRC_W), 16'($urandom),
                          8'($urandom), 8'($urandom), 1'b0, NO_CHECK);
        end
        send_beat(OP_FETCH, x, y, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_CHECK);
    endtask

    // Mostly in-range fetches; some stray loads and fetches anywhere in the field range
    task automatic random_beat();
        int          pick;
        int          ow;
        int          oh;
        logic [11:0] x;
        logic [11:0] y;
        pick = $urandom_range(0, 99);
        ow   = out_limit(scaler_cfg.out_width);
        oh   = out_limit(scaler_cfg.out_height);
        if (pick < 12)
        begin
            x = $urandom_range(0, 1) ? 12'($urandom_range(0, MAX_SRC_W - 1)) : 12'($urandom);
            y = $urandom_range(0, 1) ? 12'($urandom_range(0, MAX_SRC_H - 1)) : 12'($urandom);
            send_beat(OP_LOAD, x, y, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_CHECK);
        end
        else if (pick < 22)
        begin
            issue_fetch(12'($urandom), 12'($urandom));
        end
        else
        begin
            x = ($urandom_range(0, 99) < 10) ? 12'(ow - 1) : 12'($urandom_range(0, ow - 1));
            y = ($urandom_range(0, 99) < 10) ? 12'(oh - 1) : 12'($urandom_range(0, oh - 1));
            issue_fetch(x, y);
        end
    endtask

    // Stop offering, wait for every outstanding fetch, then let any trailing
    // load work its way through the pipe
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every accepted result beat is matched against the oldest expectation
    always @(posedge clk)
    begin
        out_pix_t got;
        out_pix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_value, out_chroma_b, out_chroma_r, status};
            if (pending_pixels.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("[%0t] result beat with no fetch waiting: value %h cb %h cr %h st %b",
                             $time, got.value, got.cb, got.cr, got.status);
            end
            else
            begin
                want = pending_pixels.pop_front();
                result_count++;
                if (got.value !== want.value || got.cb !== want.cb ||
                    got.cr !== want.cr || got.status !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"[%0t] result %0d: expected value %h cb %h cr %h st %b,",
                                  " got value %h cb %h cr %h st %b"},
                                 $time, result_count, want.value, want.cb, want.cr,
                                 want.status, got.value, got.cb, got.cr, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int start_beats;
        bit half_done;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        op          = OP_LOAD;
        coord_x     = '0;
        coord_y     = '0;
        pixel_value = '0;
        chroma_b    = '0;
        chroma_r    = '0;
        hold_req    = 1'b0;

        beat_count    = 0;
        load_count    = 0;
        dropped_count = 0;
        fetch_count   = 0;
        range_count   = 0;
        result_count  = 0;
        fault_count   = 0;

        scaler_cfg = '{src_width: 10'd512, src_height: 10'd512,
                       out_width: 13'd512, out_height: 13'd512,
                       step_x: 24'h010000, step_y: 24'h010000, color_mode: 1'b0};

        // Directed beats run on the reset settings: 512x512 both sides, step 1.0, grey.
        // Out-of-store loads sit where a wrapped address would hit (0,1) or (0,0),
        // so the fetches after them also show the drop really happened.
        directed_rows = '{
            '{1'b0, OP_LOAD,  12'd0,    12'd0,    16'hFFFF, 8'h00, 8'hFF, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd0,    12'd1,    16'h00AA, 8'h11, 8'h22, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd511,  12'd511,  16'h0000, 8'hFF, 8'h00, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd511,  12'd0,    16'h8001, 8'h80, 8'h7F, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd0,    12'd511,  16'h7FFE, 8'h01, 8'hFE, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd4095, 12'd4095, 16'h1234, 8'h55, 8'hAA, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd512,  12'd0,    16'hDEAD, 8'hBE, 8'hEF, NO_CHECK},
            '{1'b0, OP_LOAD,  12'd0,    12'd512,  16'hBEEF, 8'hCA, 8'hFE, NO_CHECK},
            '{1'b1, OP_FETCH, 12'd0,    12'd0,    16'h0000, 8'h00, 8'h00,
              '{16'hFFFF, GREY_CHROMA, GREY_CHROMA, ST_OK}},
            '{1'b1, OP_FETCH, 12'd0,    12'd1,    16'h0000, 8'h00, 8'h00,
              '{16'h00AA, GREY_CHROMA, GREY_CHROMA, ST_OK}},
            '{1'b1, OP_FETCH, 12'd511,  12'd511,  16'hFFFF, 8'hFF, 8'hFF,
              '{16'h0000, GREY_CHROMA, GREY_CHROMA, ST_OK}},
            '{1'b0, OP_FETCH, 12'd511,  12'd0,    16'h0000, 8'h00, 8'h00, NO_CHECK},
            '{1'b0, OP_FETCH, 12'd0,    12'd511,  16'h0000, 8'h00, 8'h00, NO_CHECK},
            '{1'b1, OP_FETCH, 12'd4095, 12'd4095, 16'h0000, 8'h00, 8'h00, RANGE_ERR},
            '{1'b1, OP_FETCH, 12'd512,  12'd0,    16'h0000, 8'h00, 8'h00, RANGE_ERR},
            '{1'b1, OP_FETCH, 12'd0,    12'd512,  16'h0000, 8'h00, 8'h00, RANGE_ERR},
            '{1'b1, OP_FETCH, 12'd511,  12'd512,  16'h0000, 8'h00, 8'h00, RANGE_ERR},
            '{1'b0, OP_LOAD,  12'd256,  12'd128,  16'h5A5A, 8'hC3, 8'h3C, NO_CHECK},
            '{1'b0, OP_FETCH, 12'd256,  12'd128,  16'h0000, 8'h00, 8'h00, NO_CHECK},
            '{1'b1, OP_FETCH, 12'd4095, 12'd0,    16'h0000, 8'h00, 8'h00, RANGE_ERR},
            '{1'b1, OP_FETCH, 12'd0,    12'd4095, 16'h0000, 8'h00, 8'h00, RANGE_ERR}
        };

        send_idle_pct = 14;
        recv_idle_pct = 84;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op_code, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].v, directed_rows[i].b, directed_rows[i].r,
                      directed_rows[i].chk, directed_rows[i].want);

        // Random phases. Each rewrites every register while the block is idle.
        // Idling: busy sender / sparse receiver first, then the reverse, then none.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 84;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            apply_config(pick_setting(ph));
            // With no idling, a long receiver hold-off backs the block up
            // until it stops taking input beats
            if (ph == 6)
                hold_req <= 1'b1;
            start_beats = beat_count;
            half_done   = 1'b0;
            while (beat_count - start_beats < ITEMS_PER_PHASE)
            begin
                // halfway through, the sender pauses until every fetch has returned
                if (!half_done && beat_count - start_beats >= ITEMS_PER_PHASE / 2)
                begin
                    wait_idle();
                    half_done = 1'b1;
                end
                random_beat();
            end
        end

        wait_idle();

        $display("Run covered %0d loads (%0d more dropped outside the store), %0d fetches",
                 load_count, dropped_count, fetch_count);
        $display("(%0d out of range) over reset plus %0d register settings; %0d faults",
                 range_count, NUM_PHASES, fault_count);
        if (fault_count == 0)
            $display("nearest_neighbor_image_scaler verification clean");
        else
            $display("nearest_neighbor_image_scaler verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d fetch results outstanding", pending_pixels.size());
        $display("nearest_neighbor_image_scaler verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/nnis_pkg.sv
sv/nnis_front.sv
sv/nnis_fifo.sv
sv/nnis_back.sv
sv/nearest_neighbor_image_scaler.sv
bench/nearest_neighbor_image_scaler_tb.sv
